### rtl/rdh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdh_pkg
// Shared types, widths and helpers of the radial distance histogram.
// ----------------------------------------------------------------------------
package rdh_pkg;

   localparam int NUM_BINS = 1024;
   localparam int POS_BITS = 24;

   localparam int BIN_IDX_BITS = $clog2(NUM_BINS);
   localparam int HIT_BITS     = $clog2(NUM_BINS + 1);
   localparam int CNT_BITS     = 32;
   localparam int MODE_BITS    = 2;

   // Register file
   localparam int WIDTH_BITS     = 23;
   localparam int BINS_REG_BITS  = 11;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = WIDTH_BITS;

   // Arithmetic widths
   localparam int SQ_BITS   = 2 * POS_BITS;
   localparam int ROOT_BITS = POS_BITS;
   localparam int SUB_BITS  = (ROOT_BITS + 3 > WIDTH_BITS + 1) ? ROOT_BITS + 3
                                                               : WIDTH_BITS + 1;
   localparam int STEP_BITS = $clog2(ROOT_BITS);

   // Stream widths
   localparam int REQ_FIELD_BITS = 2 * POS_BITS + BIN_IDX_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = HIT_BITS + 3 * CNT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef logic [MODE_BITS-1:0] mode_type;

   localparam mode_type MODE_ADD   = 2'd0;
   localparam mode_type MODE_ENDCF = 2'd1;
   localparam mode_type MODE_READ  = 2'd2;
   localparam mode_type MODE_CLEAR = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_BIN_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BINS_IN_USE = 2'd1;

   function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
      sat_inc = (v == {CNT_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   // Absolute value of a two's complement coordinate; the most negative
   // value maps to its unsigned magnitude.
   function automatic logic [POS_BITS-1:0] magnitude(input logic [POS_BITS-1:0] raw);
      magnitude = raw[POS_BITS-1] ? (~raw + 1'b1) : raw;
   endfunction

endpackage
`default_nettype wire

### rtl/radial_distance_histogram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radial_distance_histogram
// Histogram of radial distance: bin = floor(sqrt(x^2+y^2) / bin_width).
// ----------------------------------------------------------------------------
// Add item: squares, their sum, the bit-serial square root and division in the shared
//   subtract unit, then bin read and update. A read item goes to the bin read, end of
//   configuration to the reply, clear through a clearing pass. One item at a time: the next
//   one is taken the cycle after a result is raised, even while it waits on rsp_tready.
// Reset: counters and registers go to their reset values, then a clearing pass
//   zeroes the histogram with req_tready low.
module radial_distance_histogram
   import rdh_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Input items
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,  // pos_x, pos_y, bin_select
   input  wire logic [MODE_BITS-1:0]      req_tuser,  // mode
   // Result items
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,  // bin_hit, bin_count,
                                                      // configs_done, overflow_count
   // Register writes
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SQX   = 4'd2;
   localparam logic [3:0] S_SQY   = 4'd3;
   localparam logic [3:0] S_SUM   = 4'd4;
   localparam logic [3:0] S_ARITH = 4'd5;
   localparam logic [3:0] S_BIN   = 4'd6;
   localparam logic [3:0] S_RD    = 4'd7;
   localparam logic [3:0] S_UPD   = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   // Control state
   logic [3:0]               state_ff, state_in;
   logic                     clr_reply_ff, clr_reply_in;
   logic [BIN_IDX_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic [CNT_BITS-1:0]      cfg_cnt_ff, cfg_cnt_in;
   logic [CNT_BITS-1:0]      beyond_cnt_ff, beyond_cnt_in;
   logic [WIDTH_BITS-1:0]    bin_width_ff;
   logic [BINS_REG_BITS-1:0] bins_in_use_ff;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Item payload and working registers
   mode_type                 mode_ff, mode_in;
   logic [POS_BITS-1:0]      pos_x_ff, pos_x_in;
   logic [POS_BITS-1:0]      pos_y_ff, pos_y_in;
   logic [BIN_IDX_BITS-1:0]  addr_ff, addr_in;
   logic [SQ_BITS-1:0]       sq_ff, sq_in;
   logic [SQ_BITS-1:0]       acc_ff, acc_in;
   logic [HIT_BITS-1:0]      res_hit_ff, res_hit_in;
   logic [CNT_BITS-1:0]      res_count_ff, res_count_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // Histogram memory
   logic [CNT_BITS-1:0]      hist_mem [NUM_BINS];
   logic [CNT_BITS-1:0]      rd_data_ff;
   logic                     mem_we;
   logic [BIN_IDX_BITS-1:0]  mem_waddr;
   logic [CNT_BITS-1:0]      mem_wdata;

   // Arithmetic
   logic [POS_BITS-1:0]      mul_op;
   logic [SQ_BITS-1:0]       mul_prod;
   logic                     arith_start;
   logic                     arith_done;
   logic [ROOT_BITS-1:0]     arith_quot;
   logic [WIDTH_BITS-1:0]    eff_width;
   logic                     beyond;
   logic [CNT_BITS-1:0]      bin_next;

   rdh_root_div u_root_div (
      .clock    (clock),
      .reset    (reset),
      .start    (arith_start),
      .radicand (acc_ff + sq_ff),
      .divisor  (eff_width),
      .done     (arith_done),
      .quotient (arith_quot)
   );

   // Zero width counts as a width of one
   assign eff_width = (bin_width_ff == '0) ? WIDTH_BITS'(1) : bin_width_ff;

   // Bins past the configured count, or past the table, go to overflow
   assign beyond = (32'(arith_quot) >= 32'(bins_in_use_ff)) ||
                   (32'(arith_quot) >= 32'(NUM_BINS));

   assign mul_op      = (state_ff == S_SQX) ? magnitude(pos_x_ff) : magnitude(pos_y_ff);
   // Full-width square of one coordinate magnitude
   assign mul_prod    = mul_op * mul_op;
   assign arith_start = (state_ff == S_SUM);
   assign bin_next    = sat_inc(rd_data_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      clr_reply_in  = clr_reply_ff;
      clr_addr_in   = clr_addr_ff;
      cfg_cnt_in    = cfg_cnt_ff;
      beyond_cnt_in = beyond_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      addr_in       = addr_ff;
      sq_in         = sq_ff;
      acc_in        = acc_ff;
      res_hit_in    = res_hit_ff;
      res_count_in  = res_count_ff;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = bin_next;

      // Drop the result once the far side takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            // Zero one entry per cycle
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == BIN_IDX_BITS'(NUM_BINS - 1)) begin
               clr_addr_in = '0;
               state_in    = clr_reply_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in      = req_tuser;
               pos_x_in     = req_tdata[POS_BITS-1:0];
               pos_y_in     = req_tdata[2*POS_BITS-1:POS_BITS];
               addr_in      = req_tdata[2*POS_BITS +: BIN_IDX_BITS];
               res_hit_in   = '0;
               res_count_in = '0;
               case (req_tuser)
                  MODE_ADD: begin
                     state_in = S_SQX;
                  end
                  MODE_ENDCF: begin
                     cfg_cnt_in = sat_inc(cfg_cnt_ff);
                     state_in   = S_RESP;
                  end
                  MODE_READ: begin
                     state_in = S_RD;
                  end
                  MODE_CLEAR: begin
                     cfg_cnt_in    = '0;
                     beyond_cnt_in = '0;
                     clr_reply_in  = 1'b1;
                     clr_addr_in   = '0;
                     state_in      = S_CLEAR;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SQX: begin
            sq_in    = mul_prod;
            state_in = S_SQY;
         end
         S_SQY: begin
            acc_in   = sq_ff;
            sq_in    = mul_prod;
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_ARITH;
         end
         S_ARITH: begin
            if (arith_done) begin
               state_in = S_BIN;
            end
         end
         S_BIN: begin
            if (beyond) begin
               beyond_cnt_in = sat_inc(beyond_cnt_ff);
               res_hit_in    = HIT_BITS'(NUM_BINS);
               res_count_in  = sat_inc(beyond_cnt_ff);
               state_in      = S_RESP;
            end else begin
               addr_in  = arith_quot[BIN_IDX_BITS-1:0];
               state_in = S_RD;
            end
         end
         S_RD: begin
            // Memory read data lands in rd_data_ff
            state_in = S_UPD;
         end
         S_UPD: begin
            if (mode_ff == MODE_ADD) begin
               mem_we       = 1'b1;
               res_hit_in   = HIT_BITS'(addr_ff);
               res_count_in = bin_next;
            end else begin
               res_count_in = rd_data_ff;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_BITS'({beyond_cnt_ff, cfg_cnt_ff,
                                              res_count_ff, res_hit_ff});
               clr_reply_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_reply_ff   <= 1'b0;
         clr_addr_ff    <= '0;
         cfg_cnt_ff     <= '0;
         beyond_cnt_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         bin_width_ff   <= WIDTH_BITS'(2048);
         bins_in_use_ff <= BINS_REG_BITS'(1024);
      end else begin
         state_ff      <= state_in;
         clr_reply_ff  <= clr_reply_in;
         clr_addr_ff   <= clr_addr_in;
         cfg_cnt_ff    <= cfg_cnt_in;
         beyond_cnt_ff <= beyond_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         // Register writes; unknown indexes are ignored
         if (csr_valid) begin
            case (csr_index)
               REG_BIN_WIDTH: begin
                  bin_width_ff <= csr_data[WIDTH_BITS-1:0];
               end
               REG_BINS_IN_USE: begin
                  bins_in_use_ff <= csr_data[BINS_REG_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      mode_ff      <= mode_in;
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      addr_ff      <= addr_in;
      sq_ff        <= sq_in;
      acc_ff       <= acc_in;
      res_hit_ff   <= res_hit_in;
      res_count_ff <= res_count_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Histogram storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= hist_mem[addr_ff];
   end

endmodule
`default_nettype wire

### rtl/rdh_root_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdh_root_div
// Integer square root followed by integer division, one bit per cycle,
// both phases sharing one subtract-and-compare unit.
// ----------------------------------------------------------------------------
module rdh_root_div
   import rdh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [SQ_BITS-1:0]    radicand,
   input  wire logic [WIDTH_BITS-1:0] divisor,
   output logic                       done,
   output logic [ROOT_BITS-1:0]       quotient
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_SQRT = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   logic [1:0]            phase_ff, phase_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [SQ_BITS-1:0]    rad_ff, rad_in;
   logic [SUB_BITS-1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [WIDTH_BITS-1:0] div_ff, div_in;

   logic [SUB_BITS-1:0]   op_a, op_b;
   logic [SUB_BITS:0]     diff;
   logic                  ge;

   // Shared unit: shifted remainder against trial value or divisor
   always_comb begin
      if (phase_ff == PH_SQRT) begin
         op_a = {rem_ff[SUB_BITS-3:0], rad_ff[SQ_BITS-1 -: 2]};
         op_b = SUB_BITS'({root_ff, 2'b01});
      end else begin
         op_a = {rem_ff[SUB_BITS-2:0], root_ff[ROOT_BITS-1]};
         op_b = SUB_BITS'(div_ff);
      end
      diff = {1'b0, op_a} - {1'b0, op_b};
      ge   = ~diff[SUB_BITS];
   end

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      div_in   = div_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_SQRT;
               step_in  = STEP_BITS'(ROOT_BITS - 1);
               rad_in   = radicand;
               rem_in   = '0;
               root_in  = '0;
               div_in   = divisor;
            end
         end
         PH_SQRT, PH_DIV: begin
            rem_in  = ge ? diff[SUB_BITS-1:0] : op_a;
            root_in = {root_ff[ROOT_BITS-2:0], ge};
            rad_in  = {rad_ff[SQ_BITS-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               step_in = STEP_BITS'(ROOT_BITS - 1);
               if (phase_ff == PH_SQRT) begin
                  // Start the division from a clean remainder
                  rem_in   = '0;
                  phase_in = PH_DIV;
               end else begin
                  phase_in = PH_DONE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      step_ff <= step_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      div_ff  <= div_in;
   end

   assign done     = (phase_ff == PH_DONE);
   assign quotient = root_ff;

endmodule
`default_nettype wire
